// ----- rtl/gts_pkg.sv -----
// Shared constants and types for the geodesic triangle subdivider.
package gts_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned NUM_TRI         = 4;
  localparam int unsigned NUM_MID         = 3;

  typedef enum logic [5:0] {
    NS_IDLE = 6'b000001,
    NS_SUM  = 6'b000010,
    NS_MUL  = 6'b000100,
    NS_LEN  = 6'b001000,
    NS_SRCH = 6'b010000,
    NS_HAND = 6'b100000
  } norm_state_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
  } queue_stat_t;

endpackage

// ----- rtl/gts_if.sv -----
// Input and result channel interfaces of the subdivider.
interface gts_in_if #(parameter int unsigned W = gts_pkg::COORD_WIDTH_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z;
  modport source (output valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
                  input ready);
  modport sink (input valid, p_x, p_y, p_z, q_x, q_y, q_z, r_x, r_y, r_z,
                output ready);
endinterface

interface gts_out_if #(parameter int unsigned W = gts_pkg::COORD_WIDTH_DEF);
  logic         valid;
  logic         ready;
  logic [W-1:0] out_p_x, out_p_y, out_p_z, out_q_x, out_q_y, out_q_z;
  logic [W-1:0] out_r_x, out_r_y, out_r_z;
  logic         last_of_four;
  modport source (output valid, out_p_x, out_p_y, out_p_z, out_q_x, out_q_y, out_q_z,
                  out_r_x, out_r_y, out_r_z, last_of_four, input ready);
  modport sink (input valid, out_p_x, out_p_y, out_p_z, out_q_x, out_q_y, out_q_z,
                out_r_x, out_r_y, out_r_z, last_of_four, output ready);
endinterface

// ----- rtl/gts_front.sv -----
// Input stage: takes triangles and holds them in a two-entry queue.
module gts_front #(
  parameter int unsigned W = gts_pkg::COORD_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  gts_in_if.sink                    in_ch,
  output logic                      q_valid,
  input  logic                      q_ready,
  output logic [2:0][2:0][W-1:0]    q_tri,
  output gts_pkg::queue_stat_t      q_stat
);

  logic [2:0][2:0][W-1:0] mem_r [2];
  logic [2:0][2:0][W-1:0] wr_tri;
  logic       wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;

  assign wr_tri[0][0] = in_ch.p_x;
  assign wr_tri[0][1] = in_ch.p_y;
  assign wr_tri[0][2] = in_ch.p_z;
  assign wr_tri[1][0] = in_ch.q_x;
  assign wr_tri[1][1] = in_ch.q_y;
  assign wr_tri[1][2] = in_ch.q_z;
  assign wr_tri[2][0] = in_ch.r_x;
  assign wr_tri[2][1] = in_ch.r_y;
  assign wr_tri[2][2] = in_ch.r_z;

  assign in_ch.ready = (count_r != 2'd2);
  assign push        = in_ch.valid & in_ch.ready;
  assign q_valid     = (count_r != 2'd0);
  assign pop         = q_valid & q_ready;
  assign q_tri       = mem_r[rd_ptr_r];

  assign q_stat.count = count_r;
  assign q_stat.full  = (count_r == 2'd2);

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_tri;
    end
  end

endmodule

// ----- rtl/gts_norm.sv -----
// Midpoint unit: sums each edge and projects it to unit length, one bit a step.
module gts_norm #(
  parameter int unsigned W = gts_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_ready,
  input  logic [2:0][2:0][W-1:0] q_tri,
  output logic                   nv_valid,
  input  logic                   nv_ready,
  output logic [5:0][2:0][W-1:0] nv_vtx
);

  localparam int unsigned F  = W - 2;
  localparam int unsigned DW = 4 * W + 3;
  localparam int unsigned KW = $clog2(F + 1);

  gts_pkg::norm_state_t state_r, state_nxt;

  logic [2:0][2:0][W-1:0] tri_r;
  logic [2:0][2:0][W-1:0] mid_r;
  logic [1:0]             e_r;
  logic [KW-1:0]          k_r;
  logic signed [W:0]      s_r  [3];
  logic [2*W+1:0]         sq_r [3];
  logic signed [DW-1:0]   ls_r;
  logic signed [DW-1:0]   p_r  [3];
  logic signed [DW-1:0]   qs_r [3];
  logic signed [DW-1:0]   t_r  [3];
  logic [F:0]             cur_r [3];

  logic [2:0][W-1:0]      u_v, v_v;
  logic [W:0]             s_abs [3];
  logic signed [DW-1:0]   len;
  logic signed [DW-1:0]   pt    [3];
  logic signed [DW-1:0]   qs_up [3];
  logic [F:0]             cur_new [3];
  logic                   take  [3];
  logic [F:0]             bit_k;
  logic [W-1:0]           res   [3];

  // edge a joins p and q, b joins q and r, c joins p and r
  always_comb begin
    unique case (e_r)
      2'd0:    begin u_v = tri_r[0]; v_v = tri_r[1]; end
      2'd1:    begin u_v = tri_r[1]; v_v = tri_r[2]; end
      default: begin u_v = tri_r[0]; v_v = tri_r[2]; end
    endcase
  end

  assign bit_k = (F + 1)'(1) << k_r;
  assign len   = DW'(sq_r[0]) + DW'(sq_r[1]) + DW'(sq_r[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s_abs[i]   = s_r[i][W] ? (W + 1)'(-s_r[i]) : (W + 1)'(s_r[i]);
      pt[i]      = p_r[i] + qs_r[i] + ls_r;
      take[i]    = !cur_r[i][F] && (pt[i] <= t_r[i]);
      qs_up[i]   = take[i] ? qs_r[i] + (ls_r <<< 1) : qs_r[i];
      cur_new[i] = take[i] ? (cur_r[i] | bit_k) : cur_r[i];
      if (s_r[i] == '0) begin
        res[i] = '0;
      end else if (s_r[i][W]) begin
        res[i] = W'(-$signed({1'b0, cur_new[i]}));
      end else begin
        res[i] = W'(cur_new[i]);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gts_pkg::NS_IDLE: if (q_valid) state_nxt = gts_pkg::NS_SUM;
      gts_pkg::NS_SUM:  state_nxt = gts_pkg::NS_MUL;
      gts_pkg::NS_MUL:  state_nxt = gts_pkg::NS_LEN;
      gts_pkg::NS_LEN:  state_nxt = gts_pkg::NS_SRCH;
      gts_pkg::NS_SRCH: begin
        if (k_r == '0) begin
          state_nxt = (e_r == 2'd2) ? gts_pkg::NS_HAND : gts_pkg::NS_SUM;
        end
      end
      gts_pkg::NS_HAND: if (nv_ready) state_nxt = gts_pkg::NS_IDLE;
      default:          state_nxt = gts_pkg::NS_IDLE;
    endcase
  end

  assign q_ready  = (state_r == gts_pkg::NS_IDLE);
  assign nv_valid = (state_r == gts_pkg::NS_HAND);
  assign nv_vtx   = {mid_r, tri_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gts_pkg::NS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      gts_pkg::NS_IDLE: begin
        tri_r <= q_tri;
        e_r   <= 2'd0;
      end
      gts_pkg::NS_SUM: begin
        for (int i = 0; i < 3; i++) begin
          s_r[i] <= $signed({u_v[i][W-1], u_v[i]}) + $signed({v_v[i][W-1], v_v[i]});
        end
      end
      gts_pkg::NS_MUL: begin
        for (int i = 0; i < 3; i++) begin
          sq_r[i] <= s_abs[i] * s_abs[i];
        end
      end
      gts_pkg::NS_LEN: begin
        // trial terms are kept pre-shifted for the current bit
        ls_r <= len <<< (2 * F + 2);
        k_r  <= KW'(F);
        for (int i = 0; i < 3; i++) begin
          p_r[i]   <= len;
          qs_r[i]  <= -(len <<< (F + 2));
          t_r[i]   <= DW'(sq_r[i]) <<< (2 * F + 2);
          cur_r[i] <= '0;
        end
      end
      gts_pkg::NS_SRCH: begin
        ls_r <= ls_r >>> 2;
        k_r  <= k_r - KW'(1);
        for (int i = 0; i < 3; i++) begin
          if (take[i]) p_r[i] <= pt[i];
          qs_r[i]  <= qs_up[i] >>> 1;
          cur_r[i] <= cur_new[i];
        end
        if (k_r == '0) begin
          for (int i = 0; i < 3; i++) begin
            mid_r[e_r][i] <= res[i];
          end
          e_r <= e_r + 2'd1;
        end
      end
      gts_pkg::NS_HAND: begin
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/gts_emit.sv -----
// Output stage: holds one subdivided triangle set and sends its four triangles.
module gts_emit #(
  parameter int unsigned W = gts_pkg::COORD_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   nv_valid,
  output logic                   nv_ready,
  input  logic [5:0][2:0][W-1:0] nv_vtx,
  gts_out_if.source              out_ch
);

  localparam int unsigned VP = 0, VQ = 1, VR = 2, VA = 3, VB = 4, VC = 5;

  logic [5:0][2:0][W-1:0] vtx_r;
  logic                   busy_r, busy_nxt;
  logic [1:0]             cnt_r, cnt_nxt;
  logic                   fire, last, load;
  logic [2:0][W-1:0]      o0, o1, o2;

  assign fire     = out_ch.valid & out_ch.ready;
  assign last     = (cnt_r == 2'(gts_pkg::NUM_TRI - 1));
  assign nv_ready = !busy_r || (fire && last);
  assign load     = nv_valid & nv_ready;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (fire) begin
      cnt_nxt = cnt_r + 2'd1;
      if (last) busy_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) vtx_r <= nv_vtx;
  end

  always_comb begin
    unique case (cnt_r)
      2'd0:    begin o0 = vtx_r[VP]; o1 = vtx_r[VA]; o2 = vtx_r[VC]; end
      2'd1:    begin o0 = vtx_r[VQ]; o1 = vtx_r[VB]; o2 = vtx_r[VA]; end
      2'd2:    begin o0 = vtx_r[VR]; o1 = vtx_r[VC]; o2 = vtx_r[VB]; end
      default: begin o0 = vtx_r[VA]; o1 = vtx_r[VB]; o2 = vtx_r[VC]; end
    endcase
  end

  assign out_ch.valid        = busy_r;
  assign out_ch.last_of_four = last;
  assign out_ch.out_p_x = o0[0];
  assign out_ch.out_p_y = o0[1];
  assign out_ch.out_p_z = o0[2];
  assign out_ch.out_q_x = o1[0];
  assign out_ch.out_q_y = o1[1];
  assign out_ch.out_q_z = o1[2];
  assign out_ch.out_r_x = o2[0];
  assign out_ch.out_r_y = o2[1];
  assign out_ch.out_r_z = o2[2];

endmodule

// ----- rtl/geodesic_triangle_subdivider.sv -----
// Top level of the geodesic triangle subdivider.
// Takes a triangle p, q, r of signed Q1.(W-2) vertices and returns four triangles,
// (p,a,c), (q,b,a), (r,c,b), (a,b,c), where a, b, c are the edge midpoints pushed
// out to unit length, rounded to nearest and clamped to +-1.0; the centre triangle
// carries last_of_four. A two-entry queue takes new triangles while the midpoint
// unit works, and the output stage sends four triangles while the next set is
// computed. The midpoint unit sets the rate: it starts a new triangle only after
// handing off the last; three coordinates run in parallel, one result bit per cycle.
module geodesic_triangle_subdivider #(
  parameter int unsigned COORD_WIDTH = gts_pkg::COORD_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gts_in_if.sink    in_ch,
  gts_out_if.source out_ch
);

  localparam int unsigned F = COORD_WIDTH - 2;

  logic                             q_valid, q_ready, nv_valid, nv_ready;
  logic [2:0][2:0][COORD_WIDTH-1:0] q_tri;
  logic [5:0][2:0][COORD_WIDTH-1:0] nv_vtx;
  gts_pkg::queue_stat_t             q_stat;

  gts_front #(.W(COORD_WIDTH)) u_front (
    .clk, .rst_n, .in_ch, .q_valid, .q_ready, .q_tri, .q_stat
  );

  gts_norm #(.W(COORD_WIDTH)) u_norm (
    .clk, .rst_n, .q_valid, .q_ready, .q_tri, .nv_valid, .nv_ready, .nv_vtx
  );

  gts_emit #(.W(COORD_WIDTH)) u_emit (
    .clk, .rst_n, .nv_valid, .nv_ready, .nv_vtx, .out_ch
  );

`ifndef SYNTH
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (q_stat.full == (q_stat.count == 2'd2)) && (q_stat.count != 2'd3))
    else $error("queue count out of range");

  a_centre_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.last_of_four |->
      ($signed(out_ch.out_p_x) <= $signed(COORD_WIDTH'(1 << F))) &&
      ($signed(out_ch.out_p_x) >= -$signed(COORD_WIDTH'(1 << F))))
    else $error("centre vertex beyond unit range");

  a_hand_off: assert property (@(posedge clk) disable iff (!rst_n)
    nv_valid && nv_ready |=> out_ch.valid)
    else $error("hand-off did not start output");
`endif

endmodule
